>>> sv/b2s_pkg.sv
// blake2s engine package: initial values, message schedule, shared codes
// used by the top level sequencer and the testbench
package b2s_pkg;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_FINISH  = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_RSVD    = 2'd3;

  localparam logic [2:0] REG_OUT_LEN = 3'd0;
  localparam logic [2:0] REG_KEY_LEN = 3'd1;
  localparam logic [2:0] REG_KEY0    = 3'd2;
  localparam logic [2:0] REG_KEY1    = 3'd3;
  localparam logic [2:0] REG_KEY2    = 3'd4;
  localparam logic [2:0] REG_KEY3    = 3'd5;

  localparam logic [31:0] PARAM_BASE = 32'h0101_0000;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6A09E667;
      3'd1: r = 32'hBB67AE85;
      3'd2: r = 32'h3C6EF372;
      3'd3: r = 32'hA54FF53A;
      3'd4: r = 32'h510E527F;
      3'd5: r = 32'h9B05688C;
      3'd6: r = 32'h1F83D9AB;
      default: r = 32'h5BE0CD19;
    endcase
    return r;
  endfunction

  // message word index for round r (mod 10), slot s
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
    logic [63:0] row;
    case (r)
      4'd0: row = 64'hFEDCBA9876543210;
      4'd1: row = 64'h357B20C16DF984AE;
      4'd2: row = 64'h491763EADF250C8B;
      4'd3: row = 64'h8F04A562EBCD1397;
      4'd4: row = 64'hD386CB1EFA427509;
      4'd5: row = 64'h91EF57D438B0A6C2;
      4'd6: row = 64'hB8293670A4DEF15C;
      4'd7: row = 64'hA2684F05931CE7BD;
      4'd8: row = 64'h5A417D2C803B9EF6;
      default: row = 64'h0DC3E9BF5167482A;
    endcase
    return row[{s, 2'b00} +: 4];
  endfunction

  // indices of a, b, c, d for mix step g (0..7)
  function automatic logic [15:0] g_idx(input logic [2:0] g);
    logic [15:0] r;
    case (g)
      3'd0: r = {4'd12, 4'd8, 4'd4, 4'd0};
      3'd1: r = {4'd13, 4'd9, 4'd5, 4'd1};
      3'd2: r = {4'd14, 4'd10, 4'd6, 4'd2};
      3'd3: r = {4'd15, 4'd11, 4'd7, 4'd3};
      3'd4: r = {4'd15, 4'd10, 4'd5, 4'd0};
      3'd5: r = {4'd12, 4'd11, 4'd6, 4'd1};
      3'd6: r = {4'd13, 4'd8, 4'd7, 4'd2};
      default: r = {4'd14, 4'd9, 4'd4, 4'd3};
    endcase
    return r;
  endfunction

endpackage

>>> sv/blake2s_hash_engine.sv
// blake2s hash engine top level: sequencer, buffer, chain value, output
// depends on b2s_pkg and b2s_g_unit
//
// usage: byte-wide hashing over stream channels. s_axis_tdata carries
// {read_len, data_byte}, s_axis_tuser the kind (data, finish, restart).
// a data byte goes into the buffer unless the buffer is full and a
// further byte arrives; then a compression runs first: a load of the
// working state, ROUNDS rounds of half-steps through the shared g unit and
// a chain-value update. a finish runs the final compression once, then
// emits read_len digest bytes (saturated at 32) on m_axis, one per cycle
// while m_axis_tready is high, tlast on the last; digest bytes past
// out_len are zero. a repeated finish emits the latched digest again.
// s_axis_tready is low while a compression runs or digest bytes are
// pending; a stall on m_axis just holds the current byte. the register
// port takes out_len, key_len and the key words; they take effect at
// restart, and out_len also zeroes digest bytes as they are emitted.
// reset loads the initial state from the reset values of the registers.
module blake2s_hash_engine
  import b2s_pkg::*;
#(
  parameter int ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // data_byte[7:0], read_len[13:8]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // digest_byte[7:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);
  localparam int RW = $clog2(ROUNDS + 1);
  localparam logic [2:0] ST_IDLE = 3'd0, ST_LOAD = 3'd1, ST_ROUND = 3'd2,
                         ST_FOLD = 3'd3, ST_OUT = 3'd4;

  logic [5:0]  out_len_q, key_len_q;
  logic [63:0] key_q [4];
  logic [31:0] h_q [8];
  logic [31:0] v_q [16];
  logic [31:0] buf_q [16];
  logic [6:0]  fill_q;
  logic [63:0] cnt_q;
  logic        done_q, final_q, pend_q;
  logic [2:0]  st_q;
  logic [3:0]  step_q;
  logic        half_q;
  logic [RW-1:0] rnd_q;
  logic [3:0]  rmod_q;
  logic [7:0]  pend_byte_q;
  logic [5:0]  rd_n_q, rd_i_q;

  logic [5:0] eol, ekl;
  always_comb begin
    eol = (out_len_q == 6'd0) ? 6'd1 : (out_len_q > 6'd32) ? 6'd32 : out_len_q;
    ekl = (key_len_q > 6'd32) ? 6'd32 : key_len_q;
  end

  logic [15:0] gi;
  logic [3:0]  ia, ib, ic, id, mi;
  logic [31:0] mw, ga, gb, gc, gd;
  always_comb begin
    gi = g_idx(step_q[3:1]);
    ia = gi[3:0]; ib = gi[7:4]; ic = gi[11:8]; id = gi[15:12];
    mi = sigma(rmod_q, {step_q[3:1], half_q});
    mw = buf_q[mi];
  end

  logic [31:0] lv;
  always_comb begin
    if (step_q[3]) lv = iv_word(step_q[2:0]);
    else lv = h_q[step_q[2:0]];
    if (step_q == 4'd12) lv = iv_word(3'd4) ^ cnt_q[31:0];
    if (step_q == 4'd13) lv = iv_word(3'd5) ^ cnt_q[63:32];
    if (step_q == 4'd14) lv = final_q ? ~iv_word(3'd6) : iv_word(3'd6);
  end

  logic [31:0] kblk [16];
  logic [31:0] pblk [16];
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      kblk[i/4][(i%4)*8 +: 8] = (i < 32 && 6'(i) < ekl) ? key_q[i/8][(i%8)*8 +: 8] : 8'd0;
      pblk[i/4][(i%4)*8 +: 8] = (7'(i) >= fill_q) ? 8'd0 : buf_q[i/4][(i%4)*8 +: 8];
    end
  end

  logic [31:0] h7n;
  assign h7n = h_q[7] ^ v_q[7] ^ v_q[15];

  b2s_g_unit u_g (
    .second_i(half_q), .a_i(v_q[ia]), .b_i(v_q[ib]), .c_i(v_q[ic]), .d_i(v_q[id]),
    .m_i(mw), .a_o(ga), .b_o(gb), .c_o(gc), .d_o(gd)
  );

  logic [5:0] rl;
  assign rl = (s_axis_tdata[13:8] > 6'd32) ? 6'd32 : s_axis_tdata[13:8];
  assign s_axis_tready = (st_q == ST_IDLE);
  wire acc = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = (st_q == ST_OUT);
  assign m_axis_tdata  = (rd_i_q < eol) ?
                         buf_q[{1'b0, rd_i_q[4:2]}][{rd_i_q[1:0], 3'b000} +: 8] : 8'd0;
  assign m_axis_tlast  = (rd_i_q + 6'd1 == rd_n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q <= 6'd32;
      key_len_q <= 6'd0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      for (int i = 1; i < 8; i++) h_q[i] <= iv_word(3'(i));
      h_q[0] <= iv_word(3'd0) ^ PARAM_BASE ^ 32'd32;
      for (int i = 0; i < 16; i++) buf_q[i] <= '0;
      fill_q <= 7'd0; cnt_q <= '0; done_q <= 1'b0; final_q <= 1'b0;
      pend_q <= 1'b0; st_q <= ST_IDLE; step_q <= '0; half_q <= 1'b0;
      rnd_q <= '0; rmod_q <= '0; pend_byte_q <= '0; rd_n_q <= '0; rd_i_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i) inside
          REG_OUT_LEN: out_len_q <= cfg_wdata_i[5:0];
          REG_KEY_LEN: key_len_q <= cfg_wdata_i[5:0];
          [REG_KEY0:REG_KEY3]: key_q[cfg_idx_i[1:0] - 2'd2] <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (st_q)
        ST_IDLE: if (acc) begin
          case (s_axis_tuser)
            KIND_DATA: if (!done_q) begin
              if (fill_q[6]) begin
                cnt_q <= cnt_q + 64'd64; final_q <= 1'b0; pend_q <= 1'b1;
                pend_byte_q <= s_axis_tdata[7:0]; step_q <= '0; st_q <= ST_LOAD;
              end else begin
                buf_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= s_axis_tdata[7:0];
                fill_q <= fill_q + 7'd1;
              end
            end
            KIND_FINISH: begin
              rd_n_q <= rl; rd_i_q <= '0;
              if (!done_q) begin
                cnt_q <= cnt_q + {57'd0, fill_q};
                for (int i = 0; i < 16; i++) buf_q[i] <= pblk[i];
                final_q <= 1'b1; pend_q <= 1'b0; step_q <= '0; st_q <= ST_LOAD;
              end else if (rl != 6'd0) st_q <= ST_OUT;
            end
            KIND_RESTART: begin
              for (int i = 1; i < 8; i++) h_q[i] <= iv_word(3'(i));
              h_q[0] <= iv_word(3'd0) ^ PARAM_BASE ^ {18'd0, ekl, 8'd0} ^ {26'd0, eol};
              cnt_q <= '0; done_q <= 1'b0;
              for (int i = 0; i < 16; i++) buf_q[i] <= kblk[i];
              fill_q <= (ekl != 6'd0) ? 7'd64 : 7'd0;
            end
            default: ;
          endcase
        end
        ST_LOAD: begin
          v_q[step_q] <= lv;
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            st_q <= ST_ROUND; rnd_q <= '0; rmod_q <= '0; half_q <= 1'b0;
          end
        end
        ST_ROUND: begin
          v_q[ia] <= ga; v_q[ib] <= gb; v_q[ic] <= gc; v_q[id] <= gd;
          half_q <= ~half_q;
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            rnd_q <= rnd_q + RW'(1);
            rmod_q <= (rmod_q == 4'd9) ? 4'd0 : rmod_q + 4'd1;
            if (rnd_q == RW'(ROUNDS - 1)) st_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          h_q[step_q[2:0]] <= h_q[step_q[2:0]] ^ v_q[step_q[2:0]] ^ v_q[{1'b1, step_q[2:0]}];
          if (step_q == 4'd7) begin
            step_q <= '0;
            if (pend_q) begin
              buf_q[0][7:0] <= pend_byte_q; fill_q <= 7'd1; st_q <= ST_IDLE;
            end else begin
              for (int i = 0; i < 7; i++) buf_q[i] <= h_q[i];
              buf_q[7] <= h7n;
              done_q <= 1'b1;
              st_q <= (rd_n_q != 6'd0) ? ST_OUT : ST_IDLE;
            end
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        ST_OUT: if (m_axis_tready) begin
          rd_i_q <= rd_i_q + 6'd1;
          if (m_axis_tlast) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> sv/b2s_g_unit.sv
// blake2s half mix step: two add/xor/rotate pairs (a,d then c,b) per call
// depends on nothing beyond plain logic
module b2s_g_unit (
  input  logic        second_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  input  logic [31:0] m_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);
  logic [31:0] a1, x1, d1, c1, y1;
  always_comb begin
    a1  = a_i + b_i + m_i;
    x1  = d_i ^ a1;
    d1  = second_i ? {x1[7:0], x1[31:8]} : {x1[15:0], x1[31:16]};
    c1  = c_i + d1;
    y1  = b_i ^ c1;
    a_o = a1;
    d_o = d1;
    c_o = c1;
    b_o = second_i ? {y1[6:0], y1[31:7]} : {y1[11:0], y1[31:12]};
  end
endmodule

>>> dv/tb_top.sv
// blake2s hash engine testbench: drives bytes, finish and restart items over
// the stream ports and checks digest bytes against a behavioural blake2s model
// depends on b2s_pkg and the blake2s_hash_engine rtl
`timescale 1ns / 1ps

class digest_sb;
  logic [7:0] exp_byte_q[$];
  logic       exp_last_q[$];
  int         n_err;

  function void note(input logic [7:0] b, input logic l);
    exp_byte_q.push_back(b);
    exp_last_q.push_back(l);
  endfunction

  function void check(input logic [7:0] b, input logic l);
    logic [7:0] eb;
    logic       el;
    if (exp_byte_q.size() == 0) begin
      n_err++;
      if (n_err <= 10) $display("unexpected digest byte %02h last %0b", b, l);
      return;
    end
    eb = exp_byte_q.pop_front();
    el = exp_last_q.pop_front();
    if (eb !== b || el !== l) begin
      n_err++;
      if (n_err <= 10)
        $display("digest mismatch: exp %02h/%0b got %02h/%0b", eb, el, b, l);
    end
  endfunction
endclass

module tb_top
  import b2s_pkg::*;
();

  localparam int NROUNDS = 10;
  localparam int LIMIT   = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;

  blake2s_hash_engine #(.ROUNDS(NROUNDS)) dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  digest_sb sb = new();
  int src_idle_pct, snk_stall_pct;
  int cycles;
  int n_sent;

  // model state
  logic [5:0]  r_out_len, r_key_len;
  logic [63:0] r_key[4];
  logic [31:0] h[8];
  logic [7:0]  buf_b[64];
  int          fill;
  logic [63:0] ctr;
  bit          fin;
  logic [31:0] vw[16];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int perm_at(input int r, input int s);
    int rows[10][16] = '{
      '{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15},
      '{14,10,4,8,9,15,13,6,1,12,0,2,11,7,5,3},
      '{11,8,12,0,5,2,15,13,10,14,3,6,7,1,9,4},
      '{7,9,3,1,13,12,11,14,2,6,5,10,4,0,15,8},
      '{9,0,5,7,2,4,10,15,14,1,11,12,6,8,3,13},
      '{2,12,6,10,0,11,8,3,4,13,7,5,15,14,1,9},
      '{12,5,1,15,14,13,4,10,0,7,6,3,9,2,8,11},
      '{13,11,7,14,12,1,3,9,5,0,15,4,8,6,2,10},
      '{6,15,14,9,11,3,0,8,12,2,13,7,1,4,10,5},
      '{10,2,8,4,7,6,1,5,15,11,9,14,3,12,13,0}};
    return rows[r][s];
  endfunction

  function automatic logic [31:0] ivw(input int i);
    logic [31:0] t[8] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
                          32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
    return t[i];
  endfunction

  task automatic gmix(input int a, b, c, d, input logic [31:0] x, y);
    vw[a] = vw[a] + vw[b] + x; vw[d] = ror(vw[d] ^ vw[a], 16);
    vw[c] = vw[c] + vw[d];     vw[b] = ror(vw[b] ^ vw[c], 12);
    vw[a] = vw[a] + vw[b] + y; vw[d] = ror(vw[d] ^ vw[a], 8);
    vw[c] = vw[c] + vw[d];     vw[b] = ror(vw[b] ^ vw[c], 7);
  endtask

  task automatic compress_block(input bit last_blk);
    logic [31:0] m[16];
    for (int i = 0; i < 16; i++)
      m[i] = {buf_b[4*i+3], buf_b[4*i+2], buf_b[4*i+1], buf_b[4*i]};
    for (int i = 0; i < 8; i++) begin
      vw[i] = h[i];
      vw[i+8] = ivw(i);
    end
    vw[12] ^= ctr[31:0];
    vw[13] ^= ctr[63:32];
    if (last_blk) vw[14] = ~vw[14];
    for (int r = 0; r < NROUNDS; r++) begin
      gmix(0, 4, 8, 12, m[perm_at(r%10,0)], m[perm_at(r%10,1)]);
      gmix(1, 5, 9, 13, m[perm_at(r%10,2)], m[perm_at(r%10,3)]);
      gmix(2, 6, 10, 14, m[perm_at(r%10,4)], m[perm_at(r%10,5)]);
      gmix(3, 7, 11, 15, m[perm_at(r%10,6)], m[perm_at(r%10,7)]);
      gmix(0, 5, 10, 15, m[perm_at(r%10,8)], m[perm_at(r%10,9)]);
      gmix(1, 6, 11, 12, m[perm_at(r%10,10)], m[perm_at(r%10,11)]);
      gmix(2, 7, 8, 13, m[perm_at(r%10,12)], m[perm_at(r%10,13)]);
      gmix(3, 4, 9, 14, m[perm_at(r%10,14)], m[perm_at(r%10,15)]);
    end
    for (int i = 0; i < 8; i++) h[i] ^= vw[i] ^ vw[i+8];
  endtask

  function automatic int eff_out();
    if (r_out_len == 0) return 1;
    return r_out_len > 32 ? 32 : r_out_len;
  endfunction

  task automatic hash_restart();
    int kl;
    kl = r_key_len > 32 ? 32 : r_key_len;
    for (int i = 0; i < 8; i++) h[i] = ivw(i);
    h[0] ^= PARAM_BASE ^ (kl << 8) ^ eff_out();
    ctr = '0;
    fin = 0;
    fill = 0;
    for (int i = 0; i < 64; i++) buf_b[i] = 8'h00;
    for (int i = 0; i < kl; i++) buf_b[i] = r_key[i>>3][(i%8)*8 +: 8];
    if (kl > 0) fill = 64;
  endtask

  task automatic hash_item(input logic [1:0] kind, input logic [7:0] db,
                           input logic [5:0] rl);
    int n, ol;
    if (kind == KIND_DATA) begin
      if (fin) return;
      if (fill >= 64) begin
        ctr += 64;
        compress_block(0);
        fill = 0;
      end
      buf_b[fill] = db;
      fill++;
    end else if (kind == KIND_FINISH) begin
      n = rl > 32 ? 32 : rl;
      ol = eff_out();
      if (!fin) begin
        ctr += fill;
        while (fill < 64) begin
          buf_b[fill] = 8'h00;
          fill++;
        end
        compress_block(1);
        for (int i = 0; i < 32; i++) buf_b[i] = h[i>>2][(i%4)*8 +: 8];
        fin = 1;
      end
      for (int i = 0; i < n; i++) sb.note(i < ol ? buf_b[i] : 8'h00, i + 1 == n);
    end else if (kind == KIND_RESTART) begin
      hash_restart();
    end
  endtask

  // sink side
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send(input logic [1:0] kind, input logic [7:0] db, input logic [5:0] rl);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, rl, db};
    do @(posedge clk_i); while (!s_axis_tready);
    hash_item(kind, db, rl);
    n_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.exp_byte_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_OUT_LEN) r_out_len = val[5:0];
    else if (idx == REG_KEY_LEN) r_key_len = val[5:0];
    else if (idx >= REG_KEY0 && idx <= REG_KEY3) r_key[2'(idx - REG_KEY0)] = val;
  endtask

  task automatic msg(input int len, input int rl);
    for (int i = 0; i < len; i++)
      send(KIND_DATA, 8'($urandom_range(255)), 6'($urandom_range(63)));
    send(KIND_FINISH, 8'($urandom_range(255)), 6'(rl));
  endtask

  function automatic int pick_rl();
    int p;
    p = $urandom_range(9);
    if (p < 6) return 32;
    if (p < 8) return $urandom_range(63);
    return $urandom_range(1, 31);
  endfunction

  initial begin
    int ph;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    n_sent = 0;
    r_out_len = 32;
    r_key_len = 0;
    for (int i = 0; i < 4; i++) r_key[i] = '0;
    hash_restart();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, extremes, repeat finish, ignored data, kind 3
    send(KIND_FINISH, 8'h00, 6'd32);
    send(KIND_FINISH, 8'h00, 6'd63);
    send(KIND_DATA, 8'hFF, 6'd0);
    send(KIND_FINISH, 8'hFF, 6'd0);
    send(KIND_FINISH, 8'h00, 6'd1);
    send(KIND_RESTART, 8'h00, 6'd0);
    send(KIND_RSVD, 8'hAA, 6'h3F);
    send(KIND_DATA, 8'h00, 6'h3F);
    send(KIND_DATA, 8'hFF, 6'h2A);
    send(KIND_DATA, 8'h55, 6'h15);
    send(KIND_FINISH, 8'h00, 6'd33);
    send(KIND_RESTART, 8'h00, 6'd0);
    drain();
    cfg_write(REG_OUT_LEN, 64'd1);
    cfg_write(REG_KEY_LEN, 64'd32);
    cfg_write(REG_KEY0, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_KEY1, 64'h0123_4567_89AB_CDEF);
    cfg_write(REG_KEY2, {$urandom, $urandom});
    cfg_write(REG_KEY3, {$urandom, $urandom});
    send(KIND_RESTART, 8'h00, 6'd0);
    send(KIND_FINISH, 8'h00, 6'd32);
    send(KIND_RESTART, 8'h00, 6'd0);
    msg(3, 32);
    drain();
    cfg_write(REG_OUT_LEN, 64'd0);
    cfg_write(REG_KEY_LEN, 64'd63);
    send(KIND_RESTART, 8'h00, 6'd0);
    msg(1, 32);
    drain();
    cfg_write(REG_OUT_LEN, 64'd63);
    cfg_write(REG_KEY_LEN, 64'd0);
    send(KIND_RESTART, 8'h00, 6'd0);
    msg(64, 32);
    send(KIND_RESTART, 8'h00, 6'd0);
    msg(65, 32);
    drain();

    ph = 0;
    while (n_sent < 410) begin
      drain();
      cfg_write(REG_OUT_LEN,
                64'($urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(1, 32)));
      cfg_write(REG_KEY_LEN, 64'($urandom_range(2) == 0 ? 0 : $urandom_range(63)));
      for (int k = 0; k < 4; k++) cfg_write(3'(REG_KEY0 + k), {$urandom, $urandom});
      send(KIND_RESTART, 8'h00, 6'd0);
      for (int j = 0; j < 4 && n_sent < 410; j++) begin
        int len;
        case (ph % 4)
          0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
          1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
          2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
          default: begin src_idle_pct = 19; snk_stall_pct = 19; end
        endcase
        ph++;
        len = $urandom_range(4) == 0 ? $urandom_range(60, 100) : $urandom_range(0, 20);
        if ($urandom_range(9) == 0)
          send(KIND_RSVD, 8'($urandom_range(255)), 6'($urandom_range(63)));
        msg(len, pick_rl());
        if ($urandom_range(3) == 0) begin
          send(KIND_FINISH, 8'h00, 6'(pick_rl()));
          send(KIND_DATA, 8'($urandom_range(255)), 6'd0);
        end
        send(KIND_RESTART, 8'h00, 6'd0);
      end
    end
    drain();
    if (sb.n_err == 0 && sb.exp_byte_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> sim.f
sv/b2s_pkg.sv
sv/b2s_g_unit.sv
sv/blake2s_hash_engine.sv
dv/tb_top.sv
